// File: sv/ipv6_route_table_lpm_core_defines.svh
// Assertion macros for the IPv6 route table core.
`ifndef IPV6_ROUTE_TABLE_LPM_CORE_DEFINES_SVH
`define IPV6_ROUTE_TABLE_LPM_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define RT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: sv/rtlpm_pkg.sv
// Shared types and constants of the IPv6 route table core.
package rtlpm_pkg;
    localparam int Entries = 16;
    localparam int IdxW = 4;
    localparam logic [7:0] FullLen = 8'd128;
    localparam logic [15:0] DefaultCost = 16'd10;

    typedef enum logic [3:0] {
        ACT_LOOKUP = 4'd0, ACT_ADD = 4'd1, ACT_MODIFY = 4'd2, ACT_DELETE = 4'd3,
        ACT_GET_ACTIVE = 4'd4, ACT_SET_ACTIVE = 4'd5, ACT_SET_DEFAULT = 4'd6,
        ACT_CLR_DEFAULT = 4'd7, ACT_CLR_TABLE = 4'd8
    } action_t;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNone = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN1, S_SCAN2, S_WRITE, S_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  len;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic [15:0] iface;
        logic [15:0] cost;
        logic        active;
    } entry_t;

    typedef struct packed {
        logic [3:0]   action;
        logic [63:0]  addr_hi;
        logic [63:0]  addr_lo;
        logic [7:0]   prefix_len;
        logic [63:0]  hop_hi;
        logic [63:0]  hop_lo;
        logic [15:0]  iface;
        logic [15:0]  cost;
        logic         active_value;
    } op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic        from_default;
        logic [7:0]  out_len;
        logic [63:0] out_hop_hi;
        logic [63:0] out_hop_lo;
        logic [15:0] out_iface;
        logic [15:0] out_cost;
        logic        active_flag;
    } res_t;

    // Mask for the prefix: top len bits of a 128-bit address.
    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '1;
        if (len >= FullLen) prefix_mask = m;
        else prefix_mask = ~(m >> len[6:0]);
    endfunction
endpackage

// File: sv/rtlpm_ram.sv
// Route entry memory: one write port, one registered read port.
module rtlpm_ram (
    input  logic                     clk,
    input  logic                     we,
    input  logic [rtlpm_pkg::IdxW-1:0] waddr,
    input  rtlpm_pkg::entry_t        wdata,
    input  logic [rtlpm_pkg::IdxW-1:0] raddr,
    output rtlpm_pkg::entry_t        rdata
);
    rtlpm_pkg::entry_t mem [rtlpm_pkg::Entries];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ipv6_route_table_lpm_core.sv
// IPv6 longest-prefix route table core: 16 entries plus a default route.
// One operation per input transaction on s_axis (action, address, prefix,
// hop, iface, cost, active value); one result transaction per operation
// on m_axis (status, slot, match fields, active flag).
// The entry payload sits in a synchronous RAM with one read and one write
// port; valid bits and ages sit in flip-flops. Each scan reads one entry
// per cycle over all 16 entries. Lookup, delete and get/set active scan
// once; add scans once and writes once; modify scans twice (find the
// newest prefix match, then the free slot) and writes. The default-route,
// clear and unknown operations go from input straight to the done state,
// which registers the result.
// The next operation is taken the cycle after the result is registered.
// The result register parts input from output: a new operation is taken
// while an earlier result still waits; s_axis_tready drops while an
// operation is in flight, and an operation that finishes while the result
// register is full and stalled holds until that result is taken.
// Reset clears all valid bits, the default route and the result valid flag;
// no memory sweep is needed. A stalled receiver holds m_axis_tdata steady.
module ipv6_route_table_lpm_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[3:0], addr_hi, addr_lo, prefix_len[7:0], hop_hi, hop_lo,
    // iface[15:0], cost[15:0], active_value, zero pad (301 bits used)
    input  logic [303:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], slot[3:0], from_default, out_len[7:0], out_hop_hi,
    // out_hop_lo, out_iface[15:0], out_cost[15:0], active_flag
    output logic [175:0] m_axis_tdata
);
    localparam int N = rtlpm_pkg::Entries;
    localparam int W = rtlpm_pkg::IdxW;

    rtlpm_pkg::state_t state_reg, state_next;
    rtlpm_pkg::op_t    op_reg;
    rtlpm_pkg::res_t   res_reg;
    logic              out_valid_reg;

    logic [N-1:0]      valid_reg;
    logic [W-1:0]      age_reg [N];
    logic [W:0]        cnt_reg;       // scan read address, N marks end
    logic [W-1:0]      idx_reg;       // entry whose data is at the RAM output
    logic              rd_reg;        // RAM output holds idx_reg

    logic              best_ok_reg;
    logic [W-1:0]      best_reg;
    rtlpm_pkg::entry_t best_e_reg;
    logic              flag_reg;
    logic              dflt_valid_reg, dflt_active_reg;
    logic [63:0]       dflt_hop_hi_reg, dflt_hop_lo_reg;
    logic [15:0]       dflt_iface_reg, dflt_cost_reg;

    logic              we;
    logic [W-1:0]      waddr, raddr;
    rtlpm_pkg::entry_t wdata, rdata;

    rtlpm_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic accept, res_free, scan_end, ent_ok, hop_eq, pfx_eq, addr_eq, covered, better;
    logic [127:0] msk;
    logic [3:0]   act;

    assign s_axis_tready = (state_reg == rtlpm_pkg::S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    // result register can take a new result this cycle
    assign res_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {res_reg.active_flag, res_reg.out_cost, res_reg.out_iface,
        res_reg.out_hop_lo, res_reg.out_hop_hi, res_reg.out_len, res_reg.from_default,
        res_reg.slot, res_reg.status};
    assign act = op_reg.action;
    assign raddr = cnt_reg[W-1:0];
    assign scan_end = rd_reg && (idx_reg == W'(N-1));

    assign ent_ok  = rd_reg && valid_reg[idx_reg];
    assign hop_eq  = rdata.hop_hi == op_reg.hop_hi && rdata.hop_lo == op_reg.hop_lo;
    assign pfx_eq  = rdata.prefix_hi == op_reg.addr_hi && rdata.prefix_lo == op_reg.addr_lo;
    assign addr_eq = rdata.hop_hi == op_reg.addr_hi && rdata.hop_lo == op_reg.addr_lo;
    assign msk     = rtlpm_pkg::prefix_mask(rdata.len);
    assign covered = ((({op_reg.addr_hi, op_reg.addr_lo} ^
                       {rdata.prefix_hi, rdata.prefix_lo}) & msk) == '0);
    assign better  = !best_ok_reg || rdata.len > best_e_reg.len ||
                     (rdata.len == best_e_reg.len && age_reg[idx_reg] < age_reg[best_reg]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtlpm_pkg::S_IDLE:
                if (accept)
                begin
                    priority if (s_axis_tdata[3:0] == rtlpm_pkg::ACT_MODIFY)
                        state_next = rtlpm_pkg::S_SCAN1;
                    else if (s_axis_tdata[3:0] == rtlpm_pkg::ACT_SET_DEFAULT ||
                             s_axis_tdata[3:0] == rtlpm_pkg::ACT_CLR_DEFAULT ||
                             s_axis_tdata[3:0] == rtlpm_pkg::ACT_CLR_TABLE ||
                             s_axis_tdata[3:0] > rtlpm_pkg::ACT_CLR_TABLE)
                        state_next = rtlpm_pkg::S_DONE;
                    else
                        state_next = rtlpm_pkg::S_SCAN2;
                end
            rtlpm_pkg::S_SCAN1:
                if (scan_end) state_next = rtlpm_pkg::S_SCAN2;
            rtlpm_pkg::S_SCAN2:
                if (scan_end)
                    state_next = (act == rtlpm_pkg::ACT_ADD || act == rtlpm_pkg::ACT_MODIFY)
                                 ? rtlpm_pkg::S_WRITE : rtlpm_pkg::S_DONE;
            rtlpm_pkg::S_WRITE: state_next = rtlpm_pkg::S_DONE;
            rtlpm_pkg::S_DONE:
                // hold until the result register is free
                if (res_free) state_next = rtlpm_pkg::S_IDLE;
            default:            state_next = rtlpm_pkg::S_IDLE;
        endcase
    end

    // RAM write port: active update during scan, new entry in write state
    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = rdata;
        if (state_reg == rtlpm_pkg::S_SCAN2 && act == rtlpm_pkg::ACT_SET_ACTIVE &&
            ent_ok && hop_eq)
        begin
            we = 1'b1;
            wdata.active = op_reg.active_value;
        end
        else if (state_reg == rtlpm_pkg::S_WRITE && best_ok_reg)
        begin
            we = 1'b1;
            waddr = best_reg;
            wdata.prefix_hi = op_reg.addr_hi;
            wdata.prefix_lo = op_reg.addr_lo;
            wdata.len = (op_reg.prefix_len > rtlpm_pkg::FullLen) ? rtlpm_pkg::FullLen
                                                                 : op_reg.prefix_len;
            wdata.hop_hi = op_reg.hop_hi;
            wdata.hop_lo = op_reg.hop_lo;
            wdata.iface = op_reg.iface;
            wdata.cost = (op_reg.cost == '0) ? rtlpm_pkg::DefaultCost : op_reg.cost;
            wdata.active = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtlpm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg <= '0;
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            dflt_valid_reg <= 1'b0;
            dflt_active_reg <= 1'b0;
            dflt_hop_hi_reg <= '0;
            dflt_hop_lo_reg <= '0;
            dflt_iface_reg <= '0;
            dflt_cost_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            rd_reg <= 1'b0;
            if ((state_reg == rtlpm_pkg::S_SCAN1 || state_reg == rtlpm_pkg::S_SCAN2) &&
                cnt_reg != (W+1)'(N))
            begin
                rd_reg <= 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (scan_end)
                cnt_reg <= '0;
            unique case (state_reg)
                rtlpm_pkg::S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && s_axis_tdata[3:0] == rtlpm_pkg::ACT_SET_ACTIVE &&
                        dflt_valid_reg && dflt_hop_hi_reg == s_axis_tdata[203:140] &&
                        dflt_hop_lo_reg == s_axis_tdata[267:204])
                        dflt_active_reg <= s_axis_tdata[300];
                end
                rtlpm_pkg::S_SCAN1:
                    // modify: erase newest entry with equal prefix address at end
                    if (scan_end && (best_ok_reg || (ent_ok && pfx_eq &&
                        (!best_ok_reg || age_reg[idx_reg] < age_reg[best_reg]))))
                    begin
                        logic [W-1:0] k;
                        k = (ent_ok && pfx_eq && (!best_ok_reg ||
                             age_reg[idx_reg] < age_reg[best_reg])) ? idx_reg : best_reg;
                        valid_reg[k] <= 1'b0;
                        for (int i = 0; i < N; i++)
                            if (valid_reg[i] && age_reg[i] > age_reg[k])
                                age_reg[i] <= age_reg[i] - 1'b1;
                    end
                rtlpm_pkg::S_SCAN2:
                    if (act == rtlpm_pkg::ACT_DELETE && ent_ok && (pfx_eq || addr_eq))
                    begin
                        // ages stay dense: younger-than-erased entries unchanged
                        valid_reg[idx_reg] <= 1'b0;
                        for (int i = 0; i < N; i++)
                            if (valid_reg[i] && age_reg[i] > age_reg[idx_reg])
                                age_reg[i] <= age_reg[i] - 1'b1;
                    end
                rtlpm_pkg::S_WRITE:
                    if (best_ok_reg)
                    begin
                        for (int i = 0; i < N; i++)
                            if (valid_reg[i]) age_reg[i] <= age_reg[i] + 1'b1;
                        valid_reg[best_reg] <= 1'b1;
                        age_reg[best_reg] <= '0;
                    end
                rtlpm_pkg::S_DONE:
                    if (res_free)
                    begin
                        out_valid_reg <= 1'b1;
                        unique case (act)
                            rtlpm_pkg::ACT_SET_DEFAULT:
                            begin
                                dflt_valid_reg <= 1'b1;
                                dflt_active_reg <= 1'b0;
                                dflt_hop_hi_reg <= op_reg.hop_hi;
                                dflt_hop_lo_reg <= op_reg.hop_lo;
                                dflt_iface_reg <= op_reg.iface;
                                dflt_cost_reg <= op_reg.cost;
                            end
                            rtlpm_pkg::ACT_CLR_DEFAULT: dflt_valid_reg <= 1'b0;
                            rtlpm_pkg::ACT_CLR_TABLE:   valid_reg <= '0;
                            default: ;
                        endcase
                    end
                default: ;
            endcase
        end
    end

    // Scan tracking and result assembly (payload, no reset)
    always_ff @(posedge clk)
    begin
        idx_reg <= raddr;
        if (accept)
        begin
            op_reg <= {s_axis_tdata[3:0], s_axis_tdata[67:4], s_axis_tdata[131:68],
                       s_axis_tdata[139:132], s_axis_tdata[203:140], s_axis_tdata[267:204],
                       s_axis_tdata[283:268], s_axis_tdata[299:284], s_axis_tdata[300]};
            best_ok_reg <= 1'b0;
            best_reg <= '0;
            flag_reg <= 1'b0;
        end
        unique case (state_reg)
            rtlpm_pkg::S_SCAN1:
            begin
                if (ent_ok && pfx_eq && (!best_ok_reg || age_reg[idx_reg] < age_reg[best_reg]))
                begin
                    best_ok_reg <= 1'b1;
                    best_reg <= idx_reg;
                end
                if (scan_end)
                    best_ok_reg <= 1'b0;
            end
            rtlpm_pkg::S_SCAN2:
                unique case (act)
                    rtlpm_pkg::ACT_LOOKUP:
                        if (ent_ok && covered && better)
                        begin
                            best_ok_reg <= 1'b1;
                            best_reg <= idx_reg;
                            best_e_reg <= rdata;
                        end
                    rtlpm_pkg::ACT_ADD, rtlpm_pkg::ACT_MODIFY:
                        if (rd_reg && !valid_reg[idx_reg] && !best_ok_reg)
                        begin
                            best_ok_reg <= 1'b1;
                            best_reg <= idx_reg;
                        end
                    rtlpm_pkg::ACT_DELETE:
                        if (ent_ok && (pfx_eq || addr_eq)) flag_reg <= 1'b1;
                    rtlpm_pkg::ACT_GET_ACTIVE:
                        if (ent_ok && hop_eq && rdata.active) flag_reg <= 1'b1;
                    default: ;
                endcase
            rtlpm_pkg::S_DONE:
                if (res_free)
                begin
                    res_reg <= '0;
                    unique case (act)
                        rtlpm_pkg::ACT_LOOKUP:
                            if (best_ok_reg)
                            begin
                                res_reg.slot <= best_reg;
                                res_reg.out_len <= best_e_reg.len;
                                res_reg.out_hop_hi <= best_e_reg.hop_hi;
                                res_reg.out_hop_lo <= best_e_reg.hop_lo;
                                res_reg.out_iface <= best_e_reg.iface;
                                res_reg.out_cost <= best_e_reg.cost;
                            end
                            else if (dflt_valid_reg)
                            begin
                                res_reg.from_default <= 1'b1;
                                res_reg.out_hop_hi <= dflt_hop_hi_reg;
                                res_reg.out_hop_lo <= dflt_hop_lo_reg;
                                res_reg.out_iface <= dflt_iface_reg;
                                res_reg.out_cost <= dflt_cost_reg;
                            end
                            else
                                res_reg.status <= rtlpm_pkg::StNone;
                        rtlpm_pkg::ACT_ADD, rtlpm_pkg::ACT_MODIFY:
                            if (best_ok_reg) res_reg.slot <= best_reg;
                            else res_reg.status <= rtlpm_pkg::StFull;
                        rtlpm_pkg::ACT_DELETE:
                            res_reg.status <= flag_reg ? rtlpm_pkg::StOk : rtlpm_pkg::StNone;
                        rtlpm_pkg::ACT_GET_ACTIVE:
                        begin
                            logic a;
                            a = flag_reg || (dflt_valid_reg && dflt_active_reg &&
                                dflt_hop_hi_reg == op_reg.hop_hi &&
                                dflt_hop_lo_reg == op_reg.hop_lo);
                            res_reg.active_flag <= a;
                            res_reg.status <= a ? rtlpm_pkg::StOk : rtlpm_pkg::StNone;
                        end
                        rtlpm_pkg::ACT_SET_ACTIVE, rtlpm_pkg::ACT_SET_DEFAULT,
                        rtlpm_pkg::ACT_CLR_DEFAULT, rtlpm_pkg::ACT_CLR_TABLE: ;
                        default: res_reg.status <= rtlpm_pkg::StNone;
                    endcase
                end
            default: ;
        endcase
    end

    `include "ipv6_route_table_lpm_core_defines.svh"

    `RT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != rtlpm_pkg::S_IDLE, !s_axis_tready, "input taken while busy")
    `RT_ASSERT_NEXT(a_done_gives_result, clk, rst_n, state_reg == rtlpm_pkg::S_DONE, out_valid_reg, "no result after operation")
    `RT_ASSERT_IMP(a_write_only_in_op, clk, rst_n, we, state_reg == rtlpm_pkg::S_SCAN2 || state_reg == rtlpm_pkg::S_WRITE, "stray memory write")
endmodule
